/* design/spd_pkg.sv */
// Package for the point sorter: the control bundle that drives each sort cell,
// and the register index codes of the configuration port.
// It depends on nothing and is imported by every module of the block.
package spd_pkg;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = 2'd1;

    typedef struct packed {
        logic ins;    // place the request in its sorted slot this cycle
        logic shift;  // move every entry one cell toward the head
    } spd_ctrl_t;

endpackage

/* design/sort_points_by_distance.sv */
// Channel   Signals                                   Direction
// input     in_valid, in_stall, point_x/y, last_in    points in, stall out
// output    out_valid, out_stall, sorted_x/y,         sorted points out,
//           last_out, overflowed                      stall in
// config    cfg_wr_en, cfg_index, cfg_data            register writes
//
// A point is taken every cycle while a list builds up; its key is registered
// in the key stage and then inserted into the cell chain.
// After the last point of a list, in_stall rises and the list drains from the
// head cell, one point per cycle while out_stall is low, until all are sent.
// out_stall freezes the head cell and the whole chain with it.
// Reset clears the point count, overflow flag, reference point and busy state.
// Top level of the point sorter. Depends on spd_pkg, spd_key and spd_cell.
module sort_points_by_distance
    import spd_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [COORD_BITS-1:0]   point_x,
    input  logic [COORD_BITS-1:0]   point_y,
    input  logic                    last_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [COORD_BITS-1:0]   sorted_x,
    output logic [COORD_BITS-1:0]   sorted_y,
    output logic                    last_out,
    output logic                    overflowed
);

    localparam int KEY_BITS = 2 * COORD_BITS + 1;
    localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

    logic [COORD_BITS-1:0] ref_x_reg;
    logic [COORD_BITS-1:0] ref_y_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  emit_reg;
    logic                  emit_next;
    logic                  kv_reg;

    logic                  accept_in;
    logic                  accept_out;
    logic                  full;
    spd_ctrl_t             ctrl;

    logic [COORD_BITS-1:0] kx;
    logic [COORD_BITS-1:0] ky;
    logic                  klast;
    logic [KEY_BITS-1:0]   kkey;

    logic [COORD_BITS-1:0] cx   [MAX_POINTS];
    logic [COORD_BITS-1:0] cy   [MAX_POINTS];
    logic [KEY_BITS-1:0]   ckey [MAX_POINTS];
    logic [MAX_POINTS-1:0] cgt;

    assign in_stall   = emit_reg || (kv_reg && klast);
    assign accept_in  = in_valid && !in_stall;
    assign out_valid  = emit_reg;
    assign accept_out = emit_reg && !out_stall;
    assign full       = (count_reg == CNT_BITS'(MAX_POINTS));

    assign ctrl.ins   = kv_reg && !full;
    assign ctrl.shift = accept_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REF_X: ref_x_reg <= cfg_data;
                REG_REF_Y: ref_y_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        emit_next  = emit_reg;
        if (kv_reg)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
            if (klast)
                emit_next = 1'b1;
        end
        if (accept_out)
        begin
            count_next = count_reg - 1'b1;
            if (last_out)
            begin
                emit_next = 1'b0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= 1'b0;
            kv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            emit_reg  <= emit_next;
            kv_reg    <= accept_in;
        end
    end

    spd_key #(
        .COORD_BITS (COORD_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_key (
        .clk   (clk),
        .load  (accept_in),
        .px    (point_x),
        .py    (point_y),
        .plast (last_in),
        .rx    (ref_x_reg),
        .ry    (ref_y_reg),
        .kx    (kx),
        .ky    (ky),
        .klast (klast),
        .key   (kkey)
    );

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic                  occ;
        logic                  lgt;
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;
        logic [KEY_BITS-1:0]   lkey;
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] ry;
        logic [KEY_BITS-1:0]   rkey;

        assign occ = (CNT_BITS'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign lgt  = 1'b0;
            assign lx   = kx;
            assign ly   = ky;
            assign lkey = kkey;
        end
        else
        begin : g_body
            assign lgt  = cgt[i-1];
            assign lx   = cx[i-1];
            assign ly   = cy[i-1];
            assign lkey = ckey[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign rx   = cx[i];
            assign ry   = cy[i];
            assign rkey = ckey[i];
        end
        else
        begin : g_inner
            assign rx   = cx[i+1];
            assign ry   = cy[i+1];
            assign rkey = ckey[i+1];
        end

        spd_cell #(
            .COORD_BITS (COORD_BITS),
            .KEY_BITS   (KEY_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ),
            .left_gt   (lgt),
            .new_x     (kx),
            .new_y     (ky),
            .new_key   (kkey),
            .left_x    (lx),
            .left_y    (ly),
            .left_key  (lkey),
            .right_x   (rx),
            .right_y   (ry),
            .right_key (rkey),
            .gt        (cgt[i]),
            .x         (cx[i]),
            .y         (cy[i]),
            .key       (ckey[i])
        );
    end

    assign sorted_x   = cx[0];
    assign sorted_y   = cy[0];
    assign last_out   = (count_reg == CNT_BITS'(1));
    assign overflowed = ovf_reg;

endmodule

/* design/spd_key.sv */
// Key stage: registers one point with its exact squared distance from the
// reference point. Depends on spd_pkg.
module spd_key
    import spd_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int KEY_BITS   = 2 * COORD_BITS + 1
)
(
    input  logic                  clk,
    input  logic                  load,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic                  plast,
    input  logic [COORD_BITS-1:0] rx,
    input  logic [COORD_BITS-1:0] ry,
    output logic [COORD_BITS-1:0] kx,
    output logic [COORD_BITS-1:0] ky,
    output logic                  klast,
    output logic [KEY_BITS-1:0]   key
);

    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] dx_sq;
    logic [2*COORD_BITS-1:0] dy_sq;

    logic [COORD_BITS-1:0] kx_reg;
    logic [COORD_BITS-1:0] ky_reg;
    logic                  klast_reg;
    logic [KEY_BITS-1:0]   key_reg;

    assign dx    = (px >= rx) ? (px - rx) : (rx - px);
    assign dy    = (py >= ry) ? (py - ry) : (ry - py);
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kx_reg    <= px;
            ky_reg    <= py;
            klast_reg <= plast;
            key_reg   <= KEY_BITS'(dx_sq) + KEY_BITS'(dy_sq);
        end
    end

    assign kx    = kx_reg;
    assign ky    = ky_reg;
    assign klast = klast_reg;
    assign key   = key_reg;

endmodule

/* design/spd_cell.sv */
// One sort cell: holds a point and its key, compares the key with the incoming
// request and takes the request, its left neighbor or its right neighbor.
// Depends on spd_pkg.
module spd_cell
    import spd_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int KEY_BITS   = 2 * COORD_BITS + 1
)
(
    input  logic                  clk,
    input  spd_ctrl_t             ctrl,
    input  logic                  occupied,
    input  logic                  left_gt,
    input  logic [COORD_BITS-1:0] new_x,
    input  logic [COORD_BITS-1:0] new_y,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] left_y,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] right_y,
    input  logic [KEY_BITS-1:0]   right_key,
    output logic                  gt,
    output logic [COORD_BITS-1:0] x,
    output logic [COORD_BITS-1:0] y,
    output logic [KEY_BITS-1:0]   key
);

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [KEY_BITS-1:0]   key_reg;

    // An empty cell or a strictly larger key yields its place, which keeps
    // points of equal distance in arrival order.
    assign gt = !occupied || (key_reg > new_key);

    always_ff @(posedge clk)
    begin
        if (ctrl.ins && gt)
        begin
            if (left_gt)
            begin
                x_reg   <= left_x;
                y_reg   <= left_y;
                key_reg <= left_key;
            end
            else
            begin
                x_reg   <= new_x;
                y_reg   <= new_y;
                key_reg <= new_key;
            end
        end
        else if (ctrl.shift)
        begin
            x_reg   <= right_x;
            y_reg   <= right_y;
            key_reg <= right_key;
        end
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign key = key_reg;

endmodule

/* design/spd_checker.sv */
// Port-level checker for the point sorter, attached to the top level by bind.
// Depends on spd_pkg and sort_points_by_distance.
module spd_checker
    import spd_pkg::*;
#(
    parameter int COORD_BITS = 10
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  last_in,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COORD_BITS-1:0] sorted_x,
    input logic [COORD_BITS-1:0] sorted_y,
    input logic                  last_out,
    input logic                  overflowed
);

    // No new request is taken while a sorted list drains.
    a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while sorted list is emitted");

    // The final point of a list closes the input side right away.
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_in) |=> in_stall)
        else $error("input still open after last point");

    // A list never breaks off before its marked end.
    a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_out) |=> out_valid)
        else $error("sorted list ended without last_out");

    // After the final result the output side falls idle.
    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_out) |=> !out_valid)
        else $error("result emitted after last_out");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(sorted_x) && $stable(sorted_y)
             && $stable(last_out) && $stable(overflowed)))
        else $error("stalled result changed");

endmodule

bind sort_points_by_distance spd_checker #(
    .COORD_BITS (COORD_BITS)
) u_spd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sorted_x   (sorted_x),
    .sorted_y   (sorted_y),
    .last_out   (last_out),
    .overflowed (overflowed)
);
